@@ design/gmig_pkg.sv @@
// Shared types, register codes and helpers for the grid mesh index generator.
`default_nettype none

package gmig_pkg;

    localparam logic [7:0] MAX_CELLS = 8'd255;

    // configuration register indexes
    localparam logic [1:0] REG_LIST_MODE    = 2'd0;
    localparam logic [1:0] REG_COLUMN_COUNT = 2'd1;
    localparam logic [1:0] REG_ROW_COUNT    = 2'd2;

    // strip mode step codes
    localparam logic [2:0] STRIP_LEAD_JOIN = 3'd0;
    localparam logic [2:0] STRIP_UPPER     = 3'd1;
    localparam logic [2:0] STRIP_LOWER     = 3'd2;
    localparam logic [2:0] STRIP_TAIL_JOIN = 3'd3;

    // list mode corner codes
    localparam logic [2:0] LIST_POLE_LAST = 3'd2;
    localparam logic [2:0] LIST_QUAD_LAST = 3'd5;

    typedef struct packed {
        logic       list_mode;
        logic [7:0] cols;
        logic [7:0] rows;
    } cfg_t;

    typedef struct packed {
        logic [15:0] vertex_index;
        logic        is_join;
        logic        last;
    } result_t;

    function automatic logic [7:0] clamp_count(input logic [7:0] v);
        logic [7:0] res;
        res = v;
        if (v == 8'd0)
            res = 8'd1;
        else if (v > MAX_CELLS)
            res = MAX_CELLS;
        return res;
    endfunction

endpackage

`default_nettype wire

@@ design/gmig_cfg.sv @@
// Configuration register file; holds the clamped grid sizes and the mode.
`default_nettype none

module gmig_cfg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [7:0]        cfg_data,
    output gmig_pkg::cfg_t         cfg
);

    gmig_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.list_mode <= 1'b0;
            cfg_reg.cols      <= 8'd1;
            cfg_reg.rows      <= 8'd1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                gmig_pkg::REG_LIST_MODE:    cfg_reg.list_mode <= cfg_data[0];
                gmig_pkg::REG_COLUMN_COUNT: cfg_reg.cols <= gmig_pkg::clamp_count(cfg_data);
                gmig_pkg::REG_ROW_COUNT:    cfg_reg.rows <= gmig_pkg::clamp_count(cfg_data);
                default:                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ design/gmig_seq.sv @@
// Index sequencer: position counters and the per-item index computation.
`default_nettype none

module gmig_seq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gmig_pkg::cfg_t    cfg,
    input  wire logic              advance,
    input  wire logic              restart,
    output gmig_pkg::result_t      result
);

    logic [7:0] band_reg,   band_next;
    logic [8:0] column_reg, column_next;
    logic [2:0] step_reg,   step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_reg   <= 8'd0;
            column_reg <= 9'd0;
            step_reg   <= 3'd0;
        end
        else if (advance)
        begin
            band_reg   <= band_next;
            column_reg <= column_next;
            step_reg   <= step_next;
        end
    end

    always_comb
    begin
        logic [7:0]  b0;
        logic [8:0]  col0;
        logic [2:0]  ss0;
        logic [7:0]  b;
        logic [8:0]  col;
        logic [2:0]  ss;
        logic [8:0]  c9;
        logic [8:0]  r9;
        logic [8:0]  c1;
        logic [8:0]  b_inc;
        logic [8:0]  col_inc;
        logic        ok;
        logic        quad_done;
        logic [16:0] base;
        logic [16:0] colx;
        logic [16:0] c1x;
        logic [16:0] cx;
        logic [16:0] idx;

        c9   = {1'b0, cfg.cols};
        r9   = {1'b0, cfg.rows};
        c1   = c9 + 9'd1;
        b0   = restart ? 8'd0 : band_reg;
        col0 = restart ? 9'd0 : column_reg;
        ss0  = restart ? 3'd0 : step_reg;

        // fall back to the first index when the position lies outside the sequence
        if (!cfg.list_mode)
        begin
            if (b0 == 8'd0 && ss0 == gmig_pkg::STRIP_LEAD_JOIN)
                ss0 = gmig_pkg::STRIP_UPPER;
            ok = ({1'b0, b0} < r9) && (col0 <= c9) && (ss0 <= gmig_pkg::STRIP_TAIL_JOIN)
                 && !(ss0 == gmig_pkg::STRIP_TAIL_JOIN && ({1'b0, b0} + 9'd1 >= r9));
            b   = ok ? b0   : 8'd0;
            col = ok ? col0 : 9'd0;
            ss  = ok ? ss0  : gmig_pkg::STRIP_UPPER;
        end
        else
        begin
            ok = ({1'b0, b0} < r9) && (col0 < c9) && (ss0 <= gmig_pkg::LIST_QUAD_LAST)
                 && !(b0 == 8'd0 && ss0 > gmig_pkg::LIST_POLE_LAST);
            b   = ok ? b0   : 8'd0;
            col = ok ? col0 : 9'd0;
            ss  = ok ? ss0  : 3'd0;
        end

        b_inc   = {1'b0, b} + 9'd1;
        col_inc = col + 9'd1;
        base    = {9'd0, b} * {8'd0, c1};
        colx    = {8'd0, col};
        c1x     = {8'd0, c1};
        cx      = {8'd0, c9};

        idx         = 17'd0;
        quad_done   = 1'b0;
        result      = '0;
        band_next   = b;
        column_next = col;
        step_next   = ss;

        if (!cfg.list_mode)
        begin
            case (ss)
                gmig_pkg::STRIP_LEAD_JOIN:
                begin
                    idx            = base + c1x;
                    result.is_join = 1'b1;
                    column_next    = 9'd0;
                    step_next      = gmig_pkg::STRIP_UPPER;
                end
                gmig_pkg::STRIP_UPPER:
                begin
                    idx       = base + c1x + colx;
                    step_next = gmig_pkg::STRIP_LOWER;
                end
                gmig_pkg::STRIP_LOWER:
                begin
                    idx = base + colx;
                    if (col < c9)
                    begin
                        column_next = col_inc;
                        step_next   = gmig_pkg::STRIP_UPPER;
                    end
                    else if (b_inc < r9)
                        step_next = gmig_pkg::STRIP_TAIL_JOIN;
                    else
                    begin
                        result.last = 1'b1;
                        band_next   = 8'd0;
                        column_next = 9'd0;
                        step_next   = gmig_pkg::STRIP_LEAD_JOIN;
                    end
                end
                default:
                begin
                    idx            = base + cx;
                    result.is_join = 1'b1;
                    band_next      = b_inc[7:0];
                    column_next    = 9'd0;
                    step_next      = gmig_pkg::STRIP_LEAD_JOIN;
                end
            endcase
        end
        else
        begin
            if (b == 8'd0)
            begin
                case (ss)
                    3'd0:    idx = colx;
                    3'd1:    idx = c1x + colx + 17'd1;
                    default: idx = c1x + colx;
                endcase
                quad_done = (ss == gmig_pkg::LIST_POLE_LAST);
            end
            else
            begin
                case (ss)
                    3'd0:    idx = base + colx;
                    3'd1:    idx = base + colx + 17'd1;
                    3'd2:    idx = base + c1x + colx;
                    3'd3:    idx = base + colx + 17'd1;
                    3'd4:    idx = base + c1x + colx + 17'd1;
                    default: idx = base + c1x + colx;
                endcase
                quad_done = (ss == gmig_pkg::LIST_QUAD_LAST);
            end

            if (!quad_done)
                step_next = ss + 3'd1;
            else if (col_inc < c9)
            begin
                column_next = col_inc;
                step_next   = 3'd0;
            end
            else if (b_inc < r9)
            begin
                band_next   = b_inc[7:0];
                column_next = 9'd0;
                step_next   = 3'd0;
            end
            else
            begin
                result.last = 1'b1;
                band_next   = 8'd0;
                column_next = 9'd0;
                step_next   = 3'd0;
            end
        end

        result.vertex_index = idx[15:0];
    end

endmodule

`default_nettype wire

@@ design/grid_mesh_index_generator.sv @@
// Grid mesh index generator: one vertex index per accepted item, strip or list order.
// An accepted item passes through the input register, then the result register.
// Throughput: one item per cycle unless stalled; sequencer advances once per item moved out.
// The result register decouples the sides, so input is taken while a result waits if the input register is empty.
// Reset (rst_n low, asynchronous) empties both stages, sets strip mode, one column,
// one row, and places the sequence at its first index.
`default_nettype none

module grid_mesh_index_generator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    output      logic        in_stall,
    input  wire logic        restart,
    output      logic        out_valid,
    input  wire logic        out_stall,
    output      logic [15:0] vertex_index,
    output      logic        is_join,
    output      logic        last
);

    gmig_pkg::cfg_t    cfg;
    gmig_pkg::result_t seq_result;
    gmig_pkg::result_t out_reg;

    logic in_valid_reg;
    logic restart_reg;
    logic out_valid_reg;
    logic out_free;
    logic advance;
    logic accept;

    gmig_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gmig_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (advance),
        .restart (restart_reg),
        .result  (seq_result)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    // payload stages: restart loads on acceptance, the result on advance; both hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept)
            restart_reg <= restart;
        if (advance)
            out_reg <= seq_result;
    end

    assign out_valid    = out_valid_reg;
    assign vertex_index = out_reg.vertex_index;
    assign is_join      = out_reg.is_join;
    assign last         = out_reg.last;

endmodule

`default_nettype wire

@@ design/gmig_checker.sv @@
// Port-level checker for the grid mesh index generator, bound to the top level.
`default_nettype none

module gmig_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [15:0] vertex_index,
    input wire logic        is_join,
    input wire logic        last
);

    // an accepted item must be followed by a valid result on the result side
    a_accept_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> ##2 out_valid)
        else $error("accepted item did not reach the result register");

    // an empty result register never backs up the input
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while result register empty");

    // a join index is never the end of the sequence
    a_join_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(is_join && last))
        else $error("join index flagged as last");

    // hold the result while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(vertex_index)
                                      && $stable(is_join) && $stable(last)))
        else $error("stalled result changed");

endmodule

bind grid_mesh_index_generator gmig_checker u_gmig_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .vertex_index (vertex_index),
    .is_join      (is_join),
    .last         (last)
);

`default_nettype wire
